// ===== src/csc_pkg.sv =====
// Shared constants, item type and table functions for the CORDIC sine/cosine block.
`timescale 1ns / 1ps
`default_nettype none
package csc_pkg;

  localparam int MAX_ITERATIONS = 8;
  localparam int ANGLE_BITS     = 16;
  localparam int CFG_W          = 4;
  localparam int VALUE_W        = 16;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
  localparam int X_W            = 18;
  localparam int Z_W            = ANGLE_BITS + 1;
  localparam int ATAN_SHL       = (ANGLE_BITS >= 16) ? (ANGLE_BITS - 16) : 0;
  localparam int ATAN_SHR       = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;

  localparam int ATAN_TAB [16] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };

  localparam int GAIN_TAB [16] = '{
    11585, 10362, 10053, 9975, 9956, 9951, 9950, 9949,
    9949, 9949, 9949, 9949, 9949, 9949, 9949, 9949
  };

  typedef struct packed {
    logic                    func;
    logic                    neg_cos;
    logic [ITER_W-1:0]       iters;
    logic signed [X_W-1:0]   x;
    logic signed [X_W-1:0]   y;
    logic signed [Z_W-1:0]   z;
  } csc_item_t;

  function automatic logic signed [Z_W-1:0] atan_at(input logic [ITER_W-1:0] i);
    int t;
    t = ATAN_TAB[4'(i)];
    t = (t <<< ATAN_SHL) >>> ATAN_SHR;
    return Z_W'(t);
  endfunction

  function automatic logic signed [X_W-1:0] gain_at(input logic [ITER_W-1:0] n);
    logic [ITER_W-1:0] k;
    k = n - ITER_W'(1);
    return X_W'(GAIN_TAB[4'(k)]);
  endfunction

endpackage
`default_nettype wire

// ===== src/csc_fold.sv =====
// Input stage: quadrant fold of the angle and selection of the start gain.
`timescale 1ns / 1ps
`default_nettype none
module csc_fold import csc_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          func_i,
  input  wire logic signed [ANGLE_BITS-1:0]  angle_i,
  input  wire logic [ITER_W-1:0]             iters_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output csc_item_t                          out_item_o
);

  localparam logic signed [Z_W-1:0] HALF    = Z_W'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [Z_W-1:0] QUARTER = Z_W'(1) <<< (ANGLE_BITS - 2);

  logic      valid_q;
  csc_item_t item_q, item_d;
  logic signed [Z_W-1:0] a;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    a = Z_W'(angle_i);
    item_d.func    = func_i;
    item_d.neg_cos = 1'b0;
    item_d.iters   = iters_i;
    item_d.x       = gain_at(iters_i);
    item_d.y       = '0;
    item_d.z       = a;
    if (a > QUARTER) begin
      item_d.z       = HALF - a;
      item_d.neg_cos = 1'b1;
    end else if (a < -QUARTER) begin
      item_d.z       = -HALF - a;
      item_d.neg_cos = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule
`default_nettype wire

// ===== src/csc_stage.sv =====
// One registered CORDIC micro-rotation stage.
`timescale 1ns / 1ps
`default_nettype none
module csc_stage import csc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [ITER_W-1:0]  idx_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire csc_item_t          in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output csc_item_t               out_item_o
);

  logic      valid_q;
  csc_item_t item_q, item_d;
  logic signed [X_W-1:0] xs, ys;
  logic signed [Z_W-1:0] t;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    xs     = in_item_i.x >>> idx_i;
    ys     = in_item_i.y >>> idx_i;
    t      = atan_at(idx_i);
    item_d = in_item_i;
    if (in_item_i.iters > idx_i) begin
      if (!in_item_i.z[Z_W-1]) begin
        item_d.x = in_item_i.x - ys;
        item_d.y = in_item_i.y + xs;
        item_d.z = in_item_i.z - t;
      end else begin
        item_d.x = in_item_i.x + ys;
        item_d.y = in_item_i.y - xs;
        item_d.z = in_item_i.z + t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule
`default_nettype wire

// ===== src/cordic_sine_cosine.sv =====
// CORDIC sine/cosine: one angle per clock while the output is not held. A beat passes through
// the fold register, one register per micro-rotation and the result register. Every stage
// stalls on its own, so empty stages keep taking beats while the output is held.
// iteration_count is clamped to 1..MAX_ITERATIONS and should be written only when idle.
`timescale 1ns / 1ps
`default_nettype none
module cordic_sine_cosine import csc_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_W-1:0]              iteration_count_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          func_i,
  input  wire logic signed [ANGLE_BITS-1:0]  angle_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [VALUE_W-1:0]          value_o
);

  logic [CFG_W-1:0]  cfg_q;
  logic [ITER_W-1:0] iters;

  logic      st_v   [MAX_ITERATIONS+1];
  logic      st_rdy [MAX_ITERATIONS+1];
  csc_item_t st_item [MAX_ITERATIONS+1];

  logic                      out_v_q;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      out_rdy;
  logic signed [X_W-1:0]     res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_W'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= iteration_count_i;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      iters = ITER_W'(1);
    end else if (int'(cfg_q) > MAX_ITERATIONS) begin
      iters = ITER_W'(MAX_ITERATIONS);
    end else begin
      iters = ITER_W'(cfg_q);
    end
  end

  csc_fold u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .angle_i     (angle_i),
    .iters_i     (iters),
    .out_valid_o (st_v[0]),
    .out_ready_i (st_rdy[0]),
    .out_item_o  (st_item[0])
  );

  for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_stage
    csc_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (ITER_W'(k)),
      .in_valid_i  (st_v[k]),
      .in_ready_o  (st_rdy[k]),
      .in_item_i   (st_item[k]),
      .out_valid_o (st_v[k+1]),
      .out_ready_i (st_rdy[k+1]),
      .out_item_o  (st_item[k+1])
    );
  end

  assign st_rdy[MAX_ITERATIONS] = out_rdy;
  assign out_rdy = !out_v_q || out_ready_i;

  always_comb begin
    if (st_item[MAX_ITERATIONS].func) begin
      res = st_item[MAX_ITERATIONS].y;
    end else if (st_item[MAX_ITERATIONS].neg_cos) begin
      res = -st_item[MAX_ITERATIONS].x;
    end else begin
      res = st_item[MAX_ITERATIONS].x;
    end
    value_d = VALUE_W'(res);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= st_v[MAX_ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_v[MAX_ITERATIONS] && out_rdy) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign value_o     = value_q;

  a_iters_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iters != '0) && (int'(iters) <= MAX_ITERATIONS))
    else $error("clamped iteration count out of range");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_v_q && st_v[0] && st_v[MAX_ITERATIONS])
    else $error("input blocked while the pipeline has a bubble");

  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_v[MAX_ITERATIONS] && !out_rdy |=> st_v[MAX_ITERATIONS] && $stable(st_item[MAX_ITERATIONS]))
    else $error("stalled last stage lost or changed its beat");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_v[0] |-> (st_item[0].z <= (Z_W'(1) <<< (ANGLE_BITS - 2)))
             && (st_item[0].z >= -(Z_W'(1) <<< (ANGLE_BITS - 2))))
    else $error("folded angle beyond a quarter turn");

endmodule
`default_nettype wire

// ===== test/csc_trig_check.sv =====
// Checker for the CORDIC sine/cosine block: predicts each result and compares output beats.
`timescale 1ns / 1ps
module csc_trig_check import csc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [CFG_W-1:0]             iteration_count_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         func_i,
  input  logic signed [ANGLE_BITS-1:0] angle_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [VALUE_W-1:0]    value_i,
  output int                           pending_o,
  output int                           errors_o
);

  localparam logic [CFG_W-1:0] ITERS_AT_RESET = 4'd8;
  localparam int HALF_TURN    = 32768;
  localparam int QUARTER_TURN = 16384;

  localparam int ROT_ATAN [16] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };
  localparam int START_GAIN [16] = '{
    11585, 10362, 10053, 9975, 9956, 9951, 9950, 9949,
    9949, 9949, 9949, 9949, 9949, 9949, 9949, 9949
  };

  logic [CFG_W-1:0]   iter_setting;
  logic [VALUE_W-1:0] value_q [$];
  logic [VALUE_W-1:0] want_val;

  function automatic logic [VALUE_W-1:0] trig_value(
      input logic                         want_sine,
      input logic signed [ANGLE_BITS-1:0] ang,
      input logic [CFG_W-1:0]             iters);
    int  a;
    int  x;
    int  y;
    int  z;
    int  xs;
    int  ys;
    int  n;
    logic flip_cos;
    a        = ang;
    flip_cos = 1'b0;
    if (a > QUARTER_TURN) begin
      a        = HALF_TURN - a;
      flip_cos = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a        = -HALF_TURN - a;
      flip_cos = 1'b1;
    end
    n = iters;
    if (n < 1) n = 1;
    if (n > MAX_ITERATIONS) n = MAX_ITERATIONS;
    x = START_GAIN[n-1];
    y = 0;
    z = a;
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ROT_ATAN[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ROT_ATAN[i];
      end
    end
    if (want_sine) return VALUE_W'(y);
    return flip_cos ? VALUE_W'(-x) : VALUE_W'(x);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_setting <= ITERS_AT_RESET;
      value_q.delete();
      pending_o    <= 0;
      errors_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        iter_setting <= iteration_count_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (value_q.size() == 0) begin
          $display("%0t: unexpected result beat, actual %0d", $time, value_i);
          errors_o <= errors_o + 1;
        end else begin
          want_val = value_q.pop_front();
          if (value_i !== want_val) begin
            $display("%0t: value mismatch, expected %0d, actual %0d",
                     $time, $signed(want_val), value_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        value_q.push_back(trig_value(func_i, angle_i, iter_setting));
      end
      pending_o <= value_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the CORDIC sine/cosine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import csc_pkg::*;

  typedef enum logic {FN_COS = 1'b0, FN_SIN = 1'b1} fn_sel_e;

  localparam int  TIMEOUT_NS    = 2_000_000;
  localparam int  SETTLE_CYCLES = 24;
  localparam int  ITEMS_PER_SET = 60;
  localparam logic [CFG_W-1:0] ITER_PLAN [10] = '{
    4'd4, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd12, 4'd6, 4'd2, 4'd7
  };
  localparam logic signed [ANGLE_BITS-1:0] DIRECTED_ANGLES [12] = '{
    16'sd0, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384, 16'sd16385,
    -16'sd16385, 16'sd32767, -16'sd32768, 16'sd8192, -16'sd24576, 16'sd12345
  };
  localparam int NEAR_POINTS [4] = '{0, 16384, -16384, -32768};

  logic                         clk_i = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic [CFG_W-1:0]             cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         func_sel = 1'b0;
  logic signed [ANGLE_BITS-1:0] angle = '0;
  logic                         out_ready = 1'b0;
  logic                         cfg_ready;
  logic                         in_ready;
  logic                         out_valid;
  logic signed [VALUE_W-1:0]    value;
  int                           pending_cnt;
  int                           error_cnt;
  int                           tx_idle_pct = 30;
  int                           rx_idle_pct = 73;

  cordic_sine_cosine i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .iteration_count_i (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .func_i            (func_sel),
    .angle_i           (angle),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .value_o           (value)
  );

  csc_trig_check i_trig_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .iteration_count_i (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .func_i            (func_sel),
    .angle_i           (angle),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .value_i           (value),
    .pending_o         (pending_cnt),
    .errors_o          (error_cnt)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_angle(input fn_sel_e fn, input logic signed [ANGLE_BITS-1:0] ang);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func_sel <= fn;
    angle    <= ang;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic set_iterations(input logic [CFG_W-1:0] n);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [ANGLE_BITS-1:0] pick_angle();
    int base;
    if ($urandom_range(3) == 0) begin
      // hug the fold points and the wrap
      base = NEAR_POINTS[$urandom_range(3)];
      return ANGLE_BITS'(base + int'($urandom_range(8)) - 4);
    end
    return ANGLE_BITS'($urandom);
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    set_iterations(4'd8);
    foreach (DIRECTED_ANGLES[k]) begin
      send_angle(FN_COS, DIRECTED_ANGLES[k]);
      send_angle(FN_SIN, DIRECTED_ANGLES[k]);
    end
    wait_results_done();

    foreach (ITER_PLAN[s]) begin
      if (s < 4) begin
        tx_idle_pct = 30;
        rx_idle_pct = 73;
      end else if (s < 7) begin
        tx_idle_pct = 73;
        rx_idle_pct = 30;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_iterations(ITER_PLAN[s]);
      repeat (ITEMS_PER_SET) begin
        send_angle(fn_sel_e'($urandom_range(1)), pick_angle());
      end
      wait_results_done();
    end

    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
